[hw/rtl/fat_chain_allocator_defines.svh]
// Assertion macros for the allocator RTL.
`ifndef FAT_CHAIN_ALLOCATOR_DEFINES_SVH
`define FAT_CHAIN_ALLOCATOR_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger.
`define FCA_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define FCA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[hw/rtl/fca_pkg.sv]
// Shared types and constants for the allocation table block.
package fca_pkg;

    localparam int OP_W    = 2;
    localparam int FSIZE_W = 24;
    localparam int EIDX_W  = 10;
    localparam int STAT_W  = 2;
    localparam int OUTN_W  = 10;
    localparam int NEED_W  = FSIZE_W + 1;
    localparam int MIN_ENTRY_W = 14;
    localparam int END_MARK = 9999;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic               done;
        logic [FSIZE_W-1:0] quot;
    } t_div_res;

endpackage

[hw/rtl/fca_if.sv]
// Valid/ready channels for request and result items.
interface fca_in_if;
    import fca_pkg::*;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [FSIZE_W-1:0] file_size_bytes;
    logic [EIDX_W-1:0]  entry_index;
    modport source (output valid, opcode, file_size_bytes, entry_index, input ready);
    modport sink   (input valid, opcode, file_size_bytes, entry_index, output ready);
endinterface

interface fca_out_if;
    import fca_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OUTN_W-1:0] start_block;
    logic [OUTN_W-1:0] blocks_taken;
    logic [OUTN_W-1:0] free_left;
    modport source (output valid, status, start_block, blocks_taken, free_left, input ready);
    modport sink   (input valid, status, start_block, blocks_taken, free_left, output ready);
endinterface

[hw/rtl/fca_div.sv]
// Block count from file size: reciprocal multiplication by the block size.
module fca_div #(
    parameter int BLOCK_BYTES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fca_pkg::FSIZE_W-1:0] i_dividend,
    output fca_pkg::t_div_res           o_res
);
    import fca_pkg::*;

    // With SHIFT = FSIZE_W + ceil(log2(BLOCK_BYTES)) and RECIP = ceil(2^SHIFT / BLOCK_BYTES),
    // (x * RECIP) >> SHIFT equals x / BLOCK_BYTES for every FSIZE_W-bit x.
    localparam int DIV_LOG = $clog2(BLOCK_BYTES);
    localparam int SHIFT   = FSIZE_W + DIV_LOG;
    localparam int RECIP_W = FSIZE_W + 1;
    localparam int PROD_W  = FSIZE_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

    logic              r_go;
    logic              r_done;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] prod;

    // The dividend comes from a register loaded at the start edge, so its product is registered in the cycle after.
    assign prod = {{RECIP_W{1'b0}}, i_dividend} * {{FSIZE_W{1'b0}}, RECIP_C};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_go   <= i_start;
            r_done <= r_go;
        end
        if (r_go) begin
            r_prod <= prod;
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = FSIZE_W'(r_prod >> SHIFT);

endmodule

[hw/rtl/fat_chain_allocator.sv]
// Top level: allocation table memory and the sequencer that walks it.
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------
//  i_in     | in  | opcode, file_size_bytes, entry_index
//  o_out    | out | status, start_block, blocks_taken, free_left
//
// Allocate: the block count, then a scan that stops at the last block taken, one step
//   to end the chain and one to report; a full table reports after the count.
// Free reads the entry, clears it if it is in use and reports; clear sweeps the memory,
//   one entry per cycle, then reports.
// After reset the same clearing sweep runs before the first item is taken.
// One item is in work at a time; a new item is taken while a result waits, and the
//   next result holds in the report state until the output register is free.
`include "fat_chain_allocator_defines.svh"

module fat_chain_allocator #(
    parameter int TOTAL_BLOCKS = 1024,
    parameter int SWAP_BLOCKS  = 64,
    parameter int BLOCK_BYTES  = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fca_in_if.sink     i_in,
    fca_out_if.source  o_out
);
    import fca_pkg::*;

    localparam int DEPTH   = (TOTAL_BLOCKS > SWAP_BLOCKS) ? (TOTAL_BLOCKS - SWAP_BLOCKS) : 1;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = (IDX_W > MIN_ENTRY_W) ? IDX_W : MIN_ENTRY_W;
    localparam int CMP_W   = (IDX_W > EIDX_W) ? (IDX_W + 1) : (EIDX_W + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLR  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_FRD  = 3'd5;
    localparam logic [2:0] S_FCHK = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [2:0]         r_state, n_state;
    logic               r_clr_reply, n_clr_reply;
    logic [FSIZE_W-1:0] r_size, n_size;
    logic [EIDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]   r_free_cnt, n_free_cnt;
    logic [NEED_W-1:0]  r_need, n_need;
    logic [CNT_W-1:0]   r_got, n_got;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [IDX_W-1:0]   r_start, n_start;
    logic [IDX_W:0]     r_rd_idx, n_rd_idx;
    logic               r_chk_vld, n_chk_vld;
    logic [IDX_W-1:0]   r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic [STAT_W-1:0]  r_res_stat, n_res_stat;
    logic [IDX_W-1:0]   r_res_start, n_res_start;
    logic [CNT_W-1:0]   r_res_taken, n_res_taken;

    logic               r_out_vld, n_out_vld;
    logic [STAT_W-1:0]  r_out_stat, n_out_stat;
    logic [OUTN_W-1:0]  r_out_start, n_out_start;
    logic [OUTN_W-1:0]  r_out_taken, n_out_taken;
    logic [OUTN_W-1:0]  r_out_free, n_out_free;

    logic               in_fire;
    logic               div_start;
    t_div_res           div_res;
    logic [NEED_W-1:0]  need_calc;
    logic               idx_ok;

    fca_div #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_size),
        .o_res      (div_res)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign need_calc  = NEED_W'(div_res.quot) + 1'b1;
    assign idx_ok     = CMP_W'(r_idx) < CMP_W'(DEPTH);

    always_comb begin
        n_state     = r_state;
        n_clr_reply = r_clr_reply;
        n_size      = r_size;
        n_idx       = r_idx;
        n_free_cnt  = r_free_cnt;
        n_need      = r_need;
        n_got       = r_got;
        n_prev      = r_prev;
        n_start     = r_start;
        n_rd_idx    = r_rd_idx;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_clr_idx   = r_clr_idx;
        n_res_stat  = r_res_stat;
        n_res_start = r_res_start;
        n_res_taken = r_res_taken;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_stat  = r_out_stat;
        n_out_start = r_out_start;
        n_out_taken = r_out_taken;
        n_out_free  = r_out_free;
        div_start   = 1'b0;
        rd_addr     = r_rd_idx[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_prev;
        wr_data     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_size      = i_in.file_size_bytes;
                    n_idx       = i_in.entry_index;
                    n_res_stat  = ST_OK;
                    n_res_start = '0;
                    n_res_taken = '0;
                    case (i_in.opcode)
                        OP_ALLOC: n_state = S_DIV;
                        OP_FREE:  n_state = S_FRD;
                        OP_CLEAR: begin
                            n_state     = S_CLR;
                            n_clr_idx   = '0;
                            n_clr_reply = 1'b1;
                        end
                        default:  n_state = S_DONE;
                    endcase
                    if (i_in.opcode == OP_ALLOC) begin
                        div_start = 1'b1;
                    end
                end
            end
            S_CLR: begin
                wr_en     = 1'b1;
                wr_addr   = r_clr_idx;
                wr_data   = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                    n_free_cnt  = CNT_W'(DEPTH);
                    n_clr_reply = 1'b0;
                    n_state     = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    n_need = need_calc;
                    if (need_calc > NEED_W'(r_free_cnt)) begin
                        n_res_stat = ST_FULL;
                        n_state    = S_DONE;
                    end else begin
                        n_state  = S_SCAN;
                        n_got    = '0;
                        n_rd_idx = '0;
                    end
                end
            end
            S_SCAN: begin
                // Reads run one entry ahead of the check; links go only to
                // entries already passed, so the two never meet.
                if (r_rd_idx < (IDX_W + 1)'(DEPTH)) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else if (!r_chk_vld) begin
                    n_state = S_FIN;
                end
                if (r_chk_vld && (r_rd_data == '0)) begin
                    if (r_got == '0) begin
                        n_start = r_chk_idx;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_prev;
                        wr_data = ENTRY_W'(r_chk_idx);
                    end
                    n_prev = r_chk_idx;
                    n_got  = r_got + 1'b1;
                    if (NEED_W'(r_got) + 1'b1 == r_need) begin
                        n_state   = S_FIN;
                        n_chk_vld = 1'b0;
                    end
                end
            end
            S_FIN: begin
                wr_en       = 1'b1;
                wr_addr     = r_prev;
                wr_data     = ENTRY_W'(END_MARK);
                n_free_cnt  = r_free_cnt - r_got;
                n_res_start = r_start;
                n_res_taken = r_got;
                n_state     = S_DONE;
            end
            S_FRD: begin
                rd_addr = IDX_W'(r_idx);
                if (idx_ok) begin
                    n_state = S_FCHK;
                end else begin
                    n_res_stat = ST_RANGE;
                    n_state    = S_DONE;
                end
            end
            S_FCHK: begin
                if (r_rd_data != '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = IDX_W'(r_idx);
                    wr_data    = '0;
                    n_free_cnt = r_free_cnt + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_stat  = r_res_stat;
                    n_out_start = OUTN_W'(r_res_start);
                    n_out_taken = OUTN_W'(r_res_taken);
                    n_out_free  = OUTN_W'(r_free_cnt);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_reply <= 1'b0;
            r_clr_idx   <= '0;
            r_free_cnt  <= CNT_W'(DEPTH);
            r_chk_vld   <= 1'b0;
            r_got       <= '0;
            r_rd_idx    <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_reply <= n_clr_reply;
            r_clr_idx   <= n_clr_idx;
            r_free_cnt  <= n_free_cnt;
            r_chk_vld   <= n_chk_vld;
            r_got       <= n_got;
            r_rd_idx    <= n_rd_idx;
            r_out_vld   <= n_out_vld;
        end
        r_size      <= n_size;
        r_idx       <= n_idx;
        r_need      <= n_need;
        r_prev      <= n_prev;
        r_start     <= n_start;
        r_chk_idx   <= n_chk_idx;
        r_res_stat  <= n_res_stat;
        r_res_start <= n_res_start;
        r_res_taken <= n_res_taken;
        r_out_stat  <= n_out_stat;
        r_out_start <= n_out_start;
        r_out_taken <= n_out_taken;
        r_out_free  <= n_out_free;
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.status       = r_out_stat;
    assign o_out.start_block  = r_out_start;
    assign o_out.blocks_taken = r_out_taken;
    assign o_out.free_left    = r_out_free;

    `FCA_ASSERT_NOW(a_free_cnt_bound, 1'b1, r_free_cnt <= CNT_W'(DEPTH), "free count above depth")
    `FCA_ASSERT_NOW(a_scan_within_need, r_state == S_SCAN, NEED_W'(r_got) < r_need, "scan overran need")
    `FCA_ASSERT_NEXT(a_fin_to_done, r_state == S_FIN, r_state == S_DONE, "finish did not report")
    `FCA_ASSERT_NOW(a_fin_got_need, r_state == S_FIN, NEED_W'(r_got) == r_need, "chain length wrong")

endmodule

[tb/fat_chain_allocator_test.sv]
// Self-checking testbench for the first-fit allocation table block.
module fat_chain_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fca_pkg::*;

    localparam int FAT_DEPTH  = 1024 - 64;
    localparam int BLOCK_SIZE = 1024;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OUTN_W-1:0] start_block;
        logic [OUTN_W-1:0] blocks_taken;
        logic [OUTN_W-1:0] free_left;
    } table_result_t;

    logic clk;
    logic rst_n;
    bit   idling = 1'b1;
    int   mismatch_count = 0;

    logic [MIN_ENTRY_W-1:0] model_fat [FAT_DEPTH];
    int unsigned            model_free;
    table_result_t          pending_results [$];

    fca_in_if  req_if ();
    fca_out_if rsp_if ();

    fat_chain_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("fat_chain_allocator: mismatch");
        $finish;
    end

    function automatic void clear_model();
        foreach (model_fat[i]) model_fat[i] = '0;
        model_free = FAT_DEPTH;
    endfunction

    // Applies one item to the shadow table and returns the result it should give.
    function automatic table_result_t predict_table_op(logic [OP_W-1:0] op,
                                                      logic [FSIZE_W-1:0] size,
                                                      logic [EIDX_W-1:0] idx);
        table_result_t res;
        int unsigned   need;
        int unsigned   taken;
        int unsigned   prev;
        res   = '0;
        taken = 0;
        prev  = 0;
        case (op)
            OP_ALLOC: begin
                need = size / BLOCK_SIZE + 1;
                if (need > model_free) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < FAT_DEPTH && taken < need; i++) begin
                        if (model_fat[i] == '0) begin
                            if (taken == 0)
                                res.start_block = OUTN_W'(i);
                            else
                                model_fat[prev] = MIN_ENTRY_W'(i);
                            model_fat[i] = MIN_ENTRY_W'(END_MARK);
                            prev = i;
                            taken++;
                        end
                    end
                    model_free -= taken;
                    res.blocks_taken = OUTN_W'(taken);
                end
            end
            OP_FREE: begin
                if (idx >= FAT_DEPTH) begin
                    res.status = ST_RANGE;
                end else if (model_fat[idx] != '0) begin
                    model_fat[idx] = '0;
                    model_free++;
                end
            end
            OP_CLEAR: clear_model();
            default: ;
        endcase
        res.free_left = OUTN_W'(model_free);
        return res;
    endfunction

    // Sink side: random stall bursts while idling is enabled.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (idling && $urandom_range(0, 15) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic check_field(string field, int unsigned want, int unsigned actual);
        if (want != actual) begin
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, actual);
            mismatch_count++;
        end
    endtask

    always @(posedge clk) begin
        table_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, status %0d start %0d taken %0d free %0d",
                         $time, rsp_if.status, rsp_if.start_block, rsp_if.blocks_taken,
                         rsp_if.free_left);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(rsp_if.status));
                check_field("start_block", 32'(want.start_block), 32'(rsp_if.start_block));
                check_field("blocks_taken", 32'(want.blocks_taken),
                            32'(rsp_if.blocks_taken));
                check_field("free_left", 32'(want.free_left), 32'(rsp_if.free_left));
            end
        end
    end

    // Valid is left high after acceptance; the next call either keeps it up or idles.
    task automatic send_item(logic [OP_W-1:0] op, logic [FSIZE_W-1:0] size,
                             logic [EIDX_W-1:0] idx);
        if (idling && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.opcode          <= op;
        req_if.file_size_bytes <= size;
        req_if.entry_index     <= idx;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(predict_table_op(op, size, idx));
    endtask

    task automatic test_directed();
        send_item(OP_ALLOC, 24'd0, 10'd0);
        send_item(OP_ALLOC, 24'd1023, 10'd0);
        send_item(OP_ALLOC, 24'd1024, 10'd0);
        send_item(OP_ALLOC, 24'd5000, 10'd0);
        // Free inside a chain, then the same entry again while it is already free.
        send_item(OP_FREE, 24'd0, 10'd5);
        send_item(OP_FREE, 24'd0, 10'd5);
        send_item(OP_FREE, 24'hFFFFFF, 10'd0);
        send_item(OP_FREE, 24'd0, 10'd959);
        send_item(OP_FREE, 24'd0, 10'd960);
        send_item(OP_FREE, 24'd0, 10'h3FF);
        send_item(OP_UNUSED, 24'hFFFFFF, 10'h3FF);
        send_item(OP_ALLOC, 24'hFFFFFF, 10'h3FF);
        // First fit has to collect the holes left by the frees above.
        send_item(OP_ALLOC, 24'd3000, 10'd0);
        send_item(OP_CLEAR, 24'd0, 10'd0);
        send_item(OP_ALLOC, 24'(959 * BLOCK_SIZE + 1023), 10'd0);
        send_item(OP_ALLOC, 24'd0, 10'd0);
        send_item(OP_FREE, 24'd0, 10'd959);
        send_item(OP_FREE, 24'd0, 10'd400);
        send_item(OP_ALLOC, 24'd1024, 10'd0);
        send_item(OP_ALLOC, 24'd0, 10'd0);
        send_item(OP_CLEAR, 24'hABCDEF, 10'h2AA);
        send_item(OP_ALLOC, 24'(960 * BLOCK_SIZE), 10'd0);
        send_item(OP_FREE, 24'h555555, 10'h2AA);
    endtask

    // Mostly allocations and frees of live entries, with clears to refill the table.
    task automatic run_churn(int unsigned count);
        logic [OP_W-1:0]    op;
        logic [FSIZE_W-1:0] size;
        logic [EIDX_W-1:0]  idx;
        int unsigned        pick;
        int unsigned        tries;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            size = FSIZE_W'($urandom);
            idx  = EIDX_W'($urandom);
            if (pick < 55) begin
                op = OP_ALLOC;
                if (pick < 45)
                    size = FSIZE_W'($urandom_range(0, 16 * BLOCK_SIZE - 1));
                else if (pick < 52)
                    size = FSIZE_W'($urandom_range(0, 256 * BLOCK_SIZE));
            end else if (pick < 92) begin
                op    = OP_FREE;
                idx   = EIDX_W'($urandom_range(0, FAT_DEPTH - 1));
                tries = 0;
                while (model_fat[idx] == '0 && tries < 8) begin
                    idx = EIDX_W'($urandom_range(0, FAT_DEPTH - 1));
                    tries++;
                end
            end else if (pick < 95) begin
                op = OP_CLEAR;
            end else if (pick < 98) begin
                op  = OP_FREE;
                idx = EIDX_W'($urandom_range(FAT_DEPTH, 1023));
            end else begin
                op = OP_UNUSED;
            end
            send_item(op, size, idx);
        end
    endtask

    task automatic test_chain_churn();
        run_churn(300);
    endtask

    task automatic test_field_noise();
        repeat (150) send_item(OP_W'($urandom), FSIZE_W'($urandom), EIDX_W'($urandom));
    endtask

    task automatic test_back_to_back();
        idling = 1'b0;
        run_churn(150);
    endtask

    initial begin
        int unsigned drain_cycles;
        clear_model();
        rst_n                  <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.opcode          <= OP_ALLOC;
        req_if.file_size_bytes <= '0;
        req_if.entry_index     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_chain_churn();
        test_field_noise();
        test_back_to_back();
        req_if.valid <= 1'b0;

        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 20000) begin
            @(posedge clk);
            drain_cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("fat_chain_allocator: mismatch");
        end else begin
            repeat (1100) @(posedge clk);
            if (mismatch_count == 0)
                $display("fat_chain_allocator: match");
            else
                $display("fat_chain_allocator: mismatch");
        end
        $finish;
    end

endmodule
